>>> design/tfs_pkg.sv
// Shared constants and types for the telemetry frame serialiser.
// Used by every module in the design folder; depends on nothing.
package tfs_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned ValueW      = 16;
  localparam int unsigned ValueCount  = 5;
  localparam int unsigned PayloadW    = ValueW * ValueCount;
  localparam int unsigned PayloadB    = PayloadW / ByteW;
  localparam int unsigned HeaderB     = 4;
  localparam int unsigned CellCount   = HeaderB + PayloadB;
  localparam int unsigned PosW        = 4;

  localparam logic [ByteW-1:0] FrameHeader  = 8'hAA;
  localparam logic [ByteW-1:0] FrameDataLen = 8'd10;
  localparam logic [ByteW-1:0] DestReset    = 8'hFF;
  localparam logic [ByteW-1:0] FrameIdReset = 8'hF1;

  localparam logic [PosW-1:0] PosLastData = 4'd13;
  localparam logic [PosW-1:0] PosSumCheck = 4'd14;
  localparam logic [PosW-1:0] PosAddCheck = 4'd15;

  typedef enum logic {
    REG_DEST_ADDRESS = 1'b0,
    REG_FRAME_ID     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

>>> design/tfs_byte_cell.sv
// One byte cell of the frame shift chain.
// Loads a frame byte in parallel or takes its neighbour's byte; uses tfs_pkg.
module tfs_byte_cell (
  input  logic                        clk,
  input  tfs_pkg::cell_ctl_t          ctl,
  input  logic [tfs_pkg::ByteW-1:0]   load_byte,
  input  logic [tfs_pkg::ByteW-1:0]   shift_byte,
  output logic [tfs_pkg::ByteW-1:0]   cell_byte
);

  logic [tfs_pkg::ByteW-1:0] byte_r;
  logic [tfs_pkg::ByteW-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.shift) begin
      byte_nxt = shift_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;

endmodule

>>> design/tfs_check_unit.sv
// Running sum and sum-of-sums check accumulator for the frame bytes.
// Cleared at each frame load; uses tfs_pkg.
module tfs_check_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        accumulate,
  input  logic [tfs_pkg::ByteW-1:0]   data_byte,
  output logic [tfs_pkg::ByteW-1:0]   sum_nxt,
  output logic [tfs_pkg::ByteW-1:0]   sum_of_sums
);

  logic [tfs_pkg::ByteW-1:0] sum_r;
  logic [tfs_pkg::ByteW-1:0] sos_r;
  logic [tfs_pkg::ByteW-1:0] sos_nxt;

  assign sum_nxt = sum_r + data_byte;
  assign sos_nxt = sos_r + sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_r <= '0;
      sos_r <= '0;
    end else if (accumulate) begin
      sum_r <= sum_nxt;
      sos_r <= sos_nxt;
    end
  end

  assign sum_of_sums = sos_r;

endmodule

>>> design/telemetry_frame_serializer.sv
// Top level of the telemetry frame serialiser.
// Instantiates tfs_byte_cell and tfs_check_unit; uses tfs_pkg.
//
// Each input transaction carries five signed 16-bit values on in_tdata and
// produces one 16-byte frame on the output channel, one byte per transaction:
// header, destination, frame identifier, length, ten payload bytes (low byte
// first) and two check bytes. out_tlast marks the final check byte.
// The destination and frame identifier are set through the cfg_ write port
// and must only be changed while no frame is pending or being sent.
// An accepted item waits in a one-entry holding register and is loaded into
// a row of fourteen byte cells that shift one place towards the output per
// output transaction; the check bytes are built as the bytes leave the row.
// With an idle output an accepted item passes through the holding register
// and is then loaded into the row before its first byte appears. A new frame
// is loaded in the cycle the previous last byte is taken, so frames follow
// back to back, limited by the single-byte output channel. The next item can
// be accepted while the current frame is still being sent.
// When the receiver stalls, the current byte holds and the row stops; input
// is refused once the holding register is full. Reset empties the row and
// the holding register and restores the register defaults.
module telemetry_frame_serializer (
  input  logic                           clk,
  input  logic                           rst_n,
  // value_first [15:0] .. value_fifth [79:64]
  input  logic [tfs_pkg::PayloadW-1:0]   in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // frame_byte [7:0]
  output logic [tfs_pkg::ByteW-1:0]      out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tfs_pkg::ByteW-1:0]      cfg_wdata
);

  logic [tfs_pkg::ByteW-1:0]    dest_r;
  logic [tfs_pkg::ByteW-1:0]    frame_id_r;
  logic [tfs_pkg::PayloadW-1:0] pend_data_r;
  logic                         pend_valid_r;
  logic                         pend_valid_nxt;
  logic                         busy_r;
  logic                         busy_nxt;
  logic [tfs_pkg::PosW-1:0]     pos_r;
  logic [tfs_pkg::PosW-1:0]     pos_nxt;
  logic                         advance;
  logic                         load;
  logic                         in_accept;
  logic                         accumulate;
  logic [tfs_pkg::ByteW-1:0]    sum_nxt;
  logic [tfs_pkg::ByteW-1:0]    sum_of_sums;
  logic [tfs_pkg::ByteW-1:0]    head_shift_byte;
  tfs_pkg::cell_ctl_t           ctl;

  logic [tfs_pkg::ByteW-1:0] load_bytes  [tfs_pkg::CellCount];
  logic [tfs_pkg::ByteW-1:0] cell_bytes  [tfs_pkg::CellCount];
  logic [tfs_pkg::ByteW-1:0] shift_bytes [tfs_pkg::CellCount];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r     <= tfs_pkg::DestReset;
      frame_id_r <= tfs_pkg::FrameIdReset;
    end else if (cfg_we) begin
      unique case (tfs_pkg::reg_index_t'(cfg_index))
        tfs_pkg::REG_DEST_ADDRESS: dest_r     <= cfg_wdata;
        tfs_pkg::REG_FRAME_ID:     frame_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance    = busy_r && out_tready;
  assign load       = pend_valid_r && (!busy_r || (advance && pos_r == tfs_pkg::PosAddCheck));
  assign in_tready  = !pend_valid_r || load;
  assign in_accept  = in_tvalid && in_tready;
  assign accumulate = advance && (pos_r < tfs_pkg::PosSumCheck);

  always_comb begin
    pend_valid_nxt = (pend_valid_r && !load) || in_accept;
    busy_nxt       = busy_r;
    pos_nxt        = pos_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end else if (advance) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == tfs_pkg::PosAddCheck) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      busy_r       <= 1'b0;
      pos_r        <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      busy_r       <= busy_nxt;
      pos_r        <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_data_r <= in_tdata;
    end
  end

  assign ctl.load  = load;
  assign ctl.shift = advance;

  always_comb begin
    head_shift_byte = cell_bytes[1];
    if (pos_r == tfs_pkg::PosLastData) begin
      head_shift_byte = sum_nxt;
    end else if (pos_r == tfs_pkg::PosSumCheck) begin
      head_shift_byte = sum_of_sums;
    end
  end

  assign load_bytes[0] = tfs_pkg::FrameHeader;
  assign load_bytes[1] = dest_r;
  assign load_bytes[2] = frame_id_r;
  assign load_bytes[3] = tfs_pkg::FrameDataLen;

  for (genvar j = 0; j < tfs_pkg::PayloadB; j++) begin : g_payload
    assign load_bytes[tfs_pkg::HeaderB + j] = pend_data_r[tfs_pkg::ByteW*j +: tfs_pkg::ByteW];
  end

  assign shift_bytes[0] = head_shift_byte;
  assign shift_bytes[tfs_pkg::CellCount-1] = '0;

  for (genvar i = 1; i < tfs_pkg::CellCount - 1; i++) begin : g_link
    assign shift_bytes[i] = cell_bytes[i+1];
  end

  for (genvar i = 0; i < tfs_pkg::CellCount; i++) begin : g_cell
    tfs_byte_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_byte  (load_bytes[i]),
      .shift_byte (shift_bytes[i]),
      .cell_byte  (cell_bytes[i])
    );
  end

  tfs_check_unit u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (load),
    .accumulate  (accumulate),
    .data_byte   (cell_bytes[0]),
    .sum_nxt     (sum_nxt),
    .sum_of_sums (sum_of_sums)
  );

  assign out_tvalid = busy_r;
  assign out_tdata  = cell_bytes[0];
  assign out_tlast  = (pos_r == tfs_pkg::PosAddCheck);

endmodule

>>> verif/tb_telemetry_frame_serializer.sv
// Self-checking testbench for telemetry_frame_serializer: directed and random
// items, register changes between phases, random gaps on both stream sides.
// Depends on tfs_pkg and the design top level only.
module tb_telemetry_frame_serializer;

  import tfs_pkg::*;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems = 150;

  typedef logic [ValueCount-1:0][ValueW-1:0] payload_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [PayloadW-1:0] in_tdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    out_tdata;
  logic                out_tlast;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_DEST_ADDRESS;
  logic [ByteW-1:0]    cfg_wdata = '0;

  logic [ByteW-1:0] dest_address = DestReset;
  logic [ByteW-1:0] frame_id = FrameIdReset;
  frame_byte_t      pending_frame_bytes[$];
  int unsigned      error_count = 0;
  int unsigned      bytes_seen = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      stall_left = 0;
  bit               in_gaps_on = 1'b1;
  bit               out_stalls_on = 1'b1;

  telemetry_frame_serializer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] extremes [4];
    extremes[0] = 16'h0000;
    extremes[1] = 16'h7FFF;
    extremes[2] = 16'h8000;
    extremes[3] = 16'hFFFF;
    if ($urandom_range(0, 9) == 0) return extremes[2'($urandom_range(0, 3))];
    return ValueW'($urandom);
  endfunction

  function automatic payload_t rand_payload();
    payload_t p;
    for (int k = 0; k < ValueCount; k++) p[k] = rand_value();
    return p;
  endfunction

  function automatic payload_t same_payload(logic [ValueW-1:0] v);
    payload_t p;
    for (int k = 0; k < ValueCount; k++) p[k] = v;
    return p;
  endfunction

  function automatic void predict_frame(payload_t values);
    logic [PayloadW-1:0] flat;
    logic [ByteW-1:0]    b;
    logic [ByteW-1:0]    sum;
    logic [ByteW-1:0]    sum_of_sums;
    flat = values;
    sum = '0;
    sum_of_sums = '0;
    for (int pos = 0; pos < CellCount; pos++) begin
      case (pos)
        0: b = FrameHeader;
        1: b = dest_address;
        2: b = frame_id;
        3: b = FrameDataLen;
        default: b = flat[(pos - HeaderB) * ByteW +: ByteW];
      endcase
      pending_frame_bytes.push_back('{data: b, last: 1'b0});
      sum = sum + b;
      sum_of_sums = sum_of_sums + sum;
    end
    pending_frame_bytes.push_back('{data: sum, last: 1'b0});
    pending_frame_bytes.push_back('{data: sum_of_sums, last: 1'b1});
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR: %s at output byte %0d: got 0x%0h, expected 0x%0h",
             what, bytes_seen, got, want);
    error_count++;
  endtask

  // Output side: check every accepted transaction and stall at random.
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch("unexpected frame byte", out_tdata, 0);
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_tdata !== want.data) report_mismatch("frame_byte", out_tdata, want.data);
        if (out_tlast !== want.last) report_mismatch("frame_last", out_tlast, want.last);
      end
      bytes_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_values(input payload_t values);
    int unsigned gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= values;
    do @(posedge clk); while (!in_tready);
    predict_frame(values);
  endtask

  task automatic wait_frames_done();
    in_tvalid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [ByteW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_DEST_ADDRESS) dest_address = value;
    else frame_id = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_registers();
    payload_t mixed;
    mixed[0] = 16'h0001;
    mixed[1] = 16'h8000;
    mixed[2] = 16'h7FFF;
    mixed[3] = 16'hFFFF;
    mixed[4] = 16'h00FF;
    send_values(same_payload(16'h0000));
    send_values(same_payload(16'h7FFF));
    send_values(same_payload(16'h8000));
    send_values(same_payload(16'hFFFF));
    send_values(mixed);
    send_values(same_payload(16'h5AA5));
    wait_frames_done();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DEST_ADDRESS, 8'h00);
    write_reg(REG_FRAME_ID, 8'h00);
    send_values(same_payload(16'h0000));
    send_values(same_payload(16'hFFFF));
    wait_frames_done();
    write_reg(REG_FRAME_ID, 8'hFF);
    write_reg(REG_DEST_ADDRESS, 8'hFF);
    send_values(same_payload(16'hFFFF));
    send_values(same_payload(16'h8000));
    wait_frames_done();
    write_reg(REG_DEST_ADDRESS, 8'h55);
    write_reg(REG_FRAME_ID, 8'hAA);
    send_values(rand_payload());
    send_values(rand_payload());
    wait_frames_done();
  endtask

  task automatic test_back_to_back();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    for (int n = 0; n < 8; n++) send_values(rand_payload());
    wait_frames_done();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned sent;
    int unsigned phase_len;
    sent = 0;
    while (sent < item_total) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_DEST_ADDRESS, ByteW'($urandom_range(0, 255)));
        write_reg(REG_FRAME_ID, ByteW'($urandom_range(0, 255)));
      end else begin
        write_reg(REG_FRAME_ID, ByteW'($urandom_range(0, 255)));
        write_reg(REG_DEST_ADDRESS, ByteW'($urandom_range(0, 255)));
      end
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(10, 30);
      for (int n = 0; n < phase_len && sent < item_total; n++) begin
        send_values(rand_payload());
        sent++;
      end
      wait_frames_done();
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_register_extremes();
    test_back_to_back();
    test_random_traffic(RandomItems);
    wait_frames_done();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
